### hw/rtl/afbr_pkg.sv
package afbr_pkg;

  localparam int unsigned RingDepth = 4096;
  localparam int unsigned MaxKeep   = 2048;
  localparam int unsigned KeepCap   = (MaxKeep < RingDepth) ? MaxKeep : RingDepth;
  localparam int unsigned AddrW     = $clog2(RingDepth);
  localparam int unsigned QDepth    = 2;

  localparam logic [2:0] ModeBegin  = 3'd0;
  localparam logic [2:0] ModeData   = 3'd1;
  localparam logic [2:0] ModeRead   = 3'd2;
  localparam logic [2:0] ModeUpdate = 3'd3;
  localparam logic [2:0] ModeClear  = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StUnder    = 3'd1;
  localparam logic [2:0] StRange    = 3'd2;
  localparam logic [2:0] StOverflow = 3'd3;
  localparam logic [2:0] StNoFrame  = 3'd4;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] back_reference;
    logic [7:0]  data_in;
    logic [11:0] read_offset;
    logic [12:0] bytes_used;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  data_out;
    logic [11:0] fill_level;
    logic [12:0] assembled_length;
  } res_t;

endpackage

### hw/rtl/afbr_front.sv
module afbr_front import afbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [2:0]  mode_i,
  input  logic [11:0] back_reference_i,
  input  logic [7:0]  data_in_i,
  input  logic [11:0] read_offset_i,
  input  logic [14:0] bits_used_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  cmd_t            mem_q [QDepth];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic [15:0]     bits_ext;
  cmd_t            cmd_in;
  logic            push, pop;

  // byte count of consumed bits, rounded up
  assign bits_ext = {1'b0, bits_used_i} + 16'd7;
  always_comb begin
    cmd_in.mode           = mode_i;
    cmd_in.back_reference = back_reference_i;
    cmd_in.data_in        = data_in_i;
    cmd_in.read_offset    = read_offset_i;
    cmd_in.bytes_used     = bits_ext[15:3];
  end

  assign ready_o     = (cnt_q != 2'd2);
  assign push        = valid_i && ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hw/rtl/afbr_back.sv
module afbr_back import afbr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  typedef enum logic [2:0] {
    PhIdle  = 3'b001,
    PhGood  = 3'b010,
    PhUnder = 3'b100
  } phase_e;

  logic [7:0]       ring_q [RingDepth];
  logic [AddrW-1:0] res_start_q, res_start_d;
  logic [12:0]      res_fill_q, res_fill_d;
  logic [AddrW-1:0] asm_start_q, asm_start_d;
  logic [12:0]      asm_cnt_q, asm_cnt_d;
  phase_e           phase_q, phase_d;
  logic             out_valid_q, rd_pend_q;
  res_t             out_q, res_d;
  logic [7:0]       rd_data_q;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [AddrW-1:0] prefix;
  logic [13:0]      wide;
  logic [12:0]      over;
  logic             take;

  assign cmd_ready_o = !out_valid_q || res_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign res_valid_o = out_valid_q;

  always_comb begin
    res_o = out_q;
    if (rd_pend_q) res_o.data_out = rd_data_q;
  end

  always_comb begin
    res_start_d = res_start_q;
    res_fill_d  = res_fill_q;
    asm_start_d = asm_start_q;
    asm_cnt_d   = asm_cnt_q;
    phase_d     = phase_q;
    res_d       = '0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = res_start_q + res_fill_q[AddrW-1:0];
    rd_addr     = asm_start_q + cmd_i.read_offset[AddrW-1:0];
    prefix      = asm_start_q - res_start_q;
    wide        = '0;
    over        = '0;
    case (cmd_i.mode)
      ModeBegin: begin
        if ({1'b0, cmd_i.back_reference} <= res_fill_q) begin
          phase_d     = PhGood;
          asm_start_d = res_start_q + res_fill_q[AddrW-1:0]
                        - cmd_i.back_reference[AddrW-1:0];
          asm_cnt_d   = {1'b0, cmd_i.back_reference};
        end else begin
          phase_d     = PhUnder;
          asm_cnt_d   = '0;
          res_d.status = StUnder;
        end
      end
      ModeData: begin
        case (phase_q)
          PhUnder: begin
            wr_en        = 1'b1;
            res_d.status = StUnder;
            if (res_fill_q + 13'd1 > 13'(KeepCap)) begin
              res_start_d = res_start_q + AddrW'(1);
            end else begin
              res_fill_d = res_fill_q + 13'd1;
            end
          end
          PhGood: begin
            wide = {1'b0, 13'(prefix)} + {1'b0, asm_cnt_q};
            if (wide >= 14'(RingDepth)) begin
              res_d.status = StOverflow;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = asm_start_q + asm_cnt_q[AddrW-1:0];
              asm_cnt_d = asm_cnt_q + 13'd1;
            end
          end
          default: res_d.status = StNoFrame;
        endcase
      end
      ModeRead: begin
        if (phase_q != PhGood) begin
          res_d.status = StNoFrame;
        end else if ({1'b0, cmd_i.read_offset} >= asm_cnt_q) begin
          res_d.status = StRange;
        end else begin
          rd_en = 1'b1;
        end
      end
      ModeUpdate: begin
        case (phase_q)
          PhGood: begin
            if (cmd_i.bytes_used < asm_cnt_q) begin
              res_start_d = asm_start_q + cmd_i.bytes_used[AddrW-1:0];
              res_fill_d  = asm_cnt_q - cmd_i.bytes_used;
            end else begin
              res_start_d = asm_start_q + asm_cnt_q[AddrW-1:0];
              res_fill_d  = '0;
            end
            if (res_fill_d > 13'(KeepCap)) begin
              over        = res_fill_d - 13'(KeepCap);
              res_start_d = res_start_d + over[AddrW-1:0];
              res_fill_d  = 13'(KeepCap);
            end
            phase_d   = PhIdle;
            asm_cnt_d = '0;
          end
          PhUnder: begin
            phase_d      = PhIdle;
            asm_cnt_d    = '0;
            res_d.status = StUnder;
          end
          default: res_d.status = StNoFrame;
        endcase
      end
      ModeClear: begin
        res_start_d = '0;
        res_fill_d  = '0;
        phase_d     = PhIdle;
        asm_start_d = '0;
        asm_cnt_d   = '0;
      end
      default: ;
    endcase
    res_d.fill_level       = res_fill_d[11:0];
    res_d.assembled_length = asm_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (take && wr_en) ring_q[wr_addr] <= cmd_i.data_in;
    if (take && rd_en) rd_data_q <= ring_q[rd_addr];
    if (take) out_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_start_q <= '0;
      res_fill_q  <= '0;
      asm_start_q <= '0;
      asm_cnt_q   <= '0;
      phase_q     <= PhIdle;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      if (take) begin
        res_start_q <= res_start_d;
        res_fill_q  <= res_fill_d;
        asm_start_q <= asm_start_d;
        asm_cnt_q   <= asm_cnt_d;
        phase_q     <= phase_d;
        out_valid_q <= 1'b1;
        rd_pend_q   <= rd_en;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/audio_frame_bit_reservoir_unit.sv
// Bit reservoir byte ring for a frame-based audio decoder. One result beat
// per input beat, in order. The front end rounds bits_used up to bytes and
// parks commands in a two-entry queue; the back end executes one command per
// cycle against a 4096 x 8 ring memory (one write or one registered read per
// command), so the sustained rate is one item per clock when the output side
// keeps up. A taken beat is first parked in the front queue, then executed by
// the back end, which registers its result beat; output stalls hold the beat
// there. Ring entries never written read as unknown data.
module audio_frame_bit_reservoir_unit import afbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [11:0] back_reference_i,
  input  logic [7:0]  data_in_i,
  input  logic [11:0] read_offset_i,
  input  logic [14:0] bits_used_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  data_out_o,
  output logic [11:0] fill_level_o,
  output logic [12:0] assembled_length_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  // front: decode and queue
  afbr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (in_valid_i),
    .ready_o          (in_ready_o),
    .mode_i           (mode_i),
    .back_reference_i (back_reference_i),
    .data_in_i        (data_in_i),
    .read_offset_i    (read_offset_i),
    .bits_used_i      (bits_used_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_ready_i      (cmd_ready),
    .cmd_o            (cmd)
  );

  // back: ring and pointer state
  afbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign status_o           = res.status;
  assign data_out_o         = res.data_out;
  assign fill_level_o       = res.fill_level;
  assign assembled_length_o = res.assembled_length;

endmodule

### verif/audio_frame_bit_reservoir_unit_test.sv
`timescale 1ns / 1ps

module audio_frame_bit_reservoir_unit_test import afbr_pkg::*; ();

  // one input beat and one result beat
  typedef struct {
    logic [2:0]  mode;
    logic [11:0] back;
    logic [7:0]  din;
    logic [11:0] off;
    logic [14:0] bits;
  } cmd_beat_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  dout;
    logic [11:0] fill;
    logic [12:0] alen;
  } res_beat_t;

  typedef enum logic [2:0] {
    PhIdle  = 3'b001,
    PhGood  = 3'b010,
    PhUnder = 3'b100
  } phase_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  mode_i;
  logic [11:0] back_reference_i;
  logic [7:0]  data_in_i;
  logic [11:0] read_offset_i;
  logic [14:0] bits_used_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [7:0]  data_out_o;
  logic [11:0] fill_level_o;
  logic [12:0] assembled_length_o;

  cmd_beat_t pending_cmds[$];
  res_beat_t expected_results[$];
  int        mismatch_count;

  // shadow copy of the reservoir state
  logic [7:0]  shadow_ring [RingDepth];
  logic [11:0] res_start;
  logic [12:0] res_fill;
  phase_e      phase;
  logic [11:0] asm_start;
  logic [12:0] asm_count;

  audio_frame_bit_reservoir_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .back_reference_i  (back_reference_i),
    .data_in_i         (data_in_i),
    .read_offset_i     (read_offset_i),
    .bits_used_i       (bits_used_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .data_out_o        (data_out_o),
    .fill_level_o      (fill_level_o),
    .assembled_length_o(assembled_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // drop oldest reservoir bytes beyond the keep cap
  function automatic void trim_reservoir();
    if (res_fill > KeepCap) begin
      res_start = res_start + 12'(res_fill - KeepCap);
      res_fill  = 13'(KeepCap);
    end
  endfunction

  // apply one command to the shadow state and return the result it yields
  function automatic res_beat_t reservoir_step(cmd_beat_t c);
    res_beat_t r;
    logic [11:0] prefix;
    logic [12:0] nbytes;
    r.status = StOk;
    r.dout   = 8'd0;
    case (c.mode)
      ModeBegin: begin
        if (13'(c.back) <= res_fill) begin
          phase     = PhGood;
          asm_start = 12'(res_start + res_fill - c.back);
          asm_count = 13'(c.back);
        end else begin
          phase     = PhUnder;
          asm_count = 13'd0;
          r.status  = StUnder;
        end
      end
      ModeData: begin
        if (phase == PhUnder) begin
          shadow_ring[12'(res_start + res_fill)] = c.din;
          res_fill = res_fill + 13'd1;
          trim_reservoir();
          r.status = StUnder;
        end else if (phase == PhGood) begin
          prefix = asm_start - res_start;
          // region would run into the oldest reservoir byte
          if (13'(prefix) + asm_count >= 13'(RingDepth)) begin
            r.status = StOverflow;
          end else begin
            shadow_ring[12'(asm_start + asm_count)] = c.din;
            asm_count = asm_count + 13'd1;
          end
        end else begin
          r.status = StNoFrame;
        end
      end
      ModeRead: begin
        if (phase != PhGood) begin
          r.status = StNoFrame;
        end else if (13'(c.off) >= asm_count) begin
          r.status = StRange;
        end else begin
          r.dout = shadow_ring[asm_start + c.off];
        end
      end
      ModeUpdate: begin
        if (phase == PhGood) begin
          nbytes = 13'((16'(c.bits) + 16'd7) >> 3);
          if (nbytes < asm_count) begin
            res_start = 12'(asm_start + nbytes);
            res_fill  = asm_count - nbytes;
          end else begin
            res_start = 12'(asm_start + asm_count);
            res_fill  = 13'd0;
          end
          trim_reservoir();
          phase     = PhIdle;
          asm_count = 13'd0;
        end else if (phase == PhUnder) begin
          // refused, reservoir kept
          phase     = PhIdle;
          asm_count = 13'd0;
          r.status  = StUnder;
        end else begin
          r.status = StNoFrame;
        end
      end
      ModeClear: begin
        res_start = 12'd0;
        res_fill  = 13'd0;
        phase     = PhIdle;
        asm_start = 12'd0;
        asm_count = 13'd0;
      end
      default: ;
    endcase
    r.fill = 12'(res_fill);
    r.alen = asm_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------
  // driver: bursts of random length, random gaps in between
  // ---------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_beat_t nxt;
    bit        keep_valid;
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      mode_i           <= ModeClear;
      back_reference_i <= '0;
      data_in_i        <= '0;
      read_offset_i    <= '0;
      bits_used_i      <= '0;
      burst_left       <= 0;
      gap_left         <= 0;
      res_start = 12'd0;
      res_fill  = 13'd0;
      phase     = PhIdle;
      asm_start = 12'd0;
      asm_count = 13'd0;
    end else begin
      keep_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        // beat accepted: predict its result
        expected_results.push_back(reservoir_step(pending_cmds.pop_front()));
        keep_valid = 1'b0;
      end
      if (!keep_valid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          nxt = pending_cmds[0];
          in_valid_i       <= 1'b1;
          mode_i           <= nxt.mode;
          back_reference_i <= nxt.back;
          data_in_i        <= nxt.din;
          read_offset_i    <= nxt.off;
          bits_used_i      <= nxt.bits;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            // end of burst: long runs with no gap now and then
            burst_left <= $urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 8);
            gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: receiver stalls on its own pattern, checks each beat
  // ---------------------------------------------------------------
  int stall_phase;

  always @(posedge clk_i or negedge rst_ni) begin
    res_beat_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", status_o, -1);
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", status_o, want.status);
          if (data_out_o !== want.dout)
            report_mismatch("data_out", data_out_o, want.dout);
          if (fill_level_o !== want.fill)
            report_mismatch("fill_level", fill_level_o, want.fill);
          if (assembled_length_o !== want.alen)
            report_mismatch("assembled_length", assembled_length_o, want.alen);
        end
      end
      // repeating pattern: one quarter always ready, rest ready at random
      stall_phase <= (stall_phase + 1) % 64;
      out_ready_i <= (stall_phase < 16) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------
  task automatic queue_cmd(logic [2:0] m, int back, int din, int off, int bits);
    cmd_beat_t c;
    c.mode = m;
    c.back = 12'(back);
    c.din  = 8'(din);
    c.off  = 12'(off);
    c.bits = 15'(bits);
    pending_cmds.push_back(c);
  endtask

  // noise in the fields a mode does not use
  task automatic queue_op(logic [2:0] m, int arg);
    int back = $urandom_range(0, 4095);
    int din  = $urandom_range(0, 255);
    int off  = $urandom_range(0, 4095);
    int bits = $urandom_range(0, 32767);
    case (m)
      ModeBegin:  back = arg;
      ModeData:   din  = arg;
      ModeRead:   off  = arg;
      ModeUpdate: bits = arg;
      default: ;
    endcase
    queue_cmd(m, back, din, off, bits);
  endtask

  // frame: begin, data bytes with reads mixed in, and an update most of the time
  task automatic queue_frame(int back, int nbytes);
    int span = back + nbytes;
    for (int i = 0; i < 1; i++) queue_op(ModeBegin, back);
    for (int i = 0; i < nbytes; i++) begin
      queue_op(ModeData, $urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0)
        queue_op(ModeRead, $urandom_range(0, 7) == 0 ? $urandom_range(0, 4095)
                                                     : $urandom_range(0, span));
    end
    if ($urandom_range(0, 9) != 0)
      queue_op(ModeUpdate, $urandom_range(0, 5) == 0 ? $urandom_range(0, 32767)
                                                     : $urandom_range(0, 8 * span + 8));
  endtask

  initial begin
    int start_count;
    mismatch_count = 0;

    // directed: no-frame cases, empty good frame, underflow, full consume
    queue_op(ModeClear, 0);
    queue_op(ModeUpdate, 0);
    queue_op(ModeData, 8'hA5);
    queue_op(ModeRead, 0);
    queue_op(ModeBegin, 0);
    queue_op(ModeRead, 0);
    queue_op(ModeData, 255);
    queue_op(ModeData, 0);
    queue_op(ModeRead, 1);
    queue_op(ModeRead, 4095);
    queue_op(ModeUpdate, 0);
    queue_op(ModeBegin, 2048);
    queue_op(ModeData, 8'hA5 ^ 8'hFF);
    queue_op(ModeRead, 0);
    queue_op(ModeUpdate, 32767);
    queue_op(ModeBegin, 1);
    queue_op(ModeBegin, 3);
    queue_op(ModeBegin, 2);
    queue_op(ModeRead, 0);
    queue_op(ModeUpdate, 32767);
    queue_op(ModeBegin, 0);
    queue_op(ModeUpdate, 1);
    queue_op(ModeClear, 0);

    // random frames, mostly well formed, unknown modes now and then
    start_count = pending_cmds.size();
    while (pending_cmds.size() - start_count < 750) begin
      case ($urandom_range(0, 9))
        0:       queue_op(3'($urandom_range(1, 7)), 0);
        1:       queue_frame($urandom_range(0, 4095) % 2049, $urandom_range(0, 6));
        2, 3:    queue_frame($urandom_range(20, 200), $urandom_range(10, 60));
        default: queue_frame($urandom_range(0, 24), $urandom_range(0, 30));
      endcase
    end
    queue_frame(100, 20);

    wait (rst_ni);
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20ns * 200000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
